/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the heading turn control RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check, live during reset too.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/pht_pkg.sv */
// ----------------------------------------------------------------------------
// pht_pkg
// Shared widths, register map, reset values and inter-stage types.
// ----------------------------------------------------------------------------
package pht_pkg;

    localparam int GYRO_W     = 16;
    localparam int GAIN_W     = 24;
    localparam int ERR_W      = 25;
    localparam int INTEG_W    = 18;
    localparam int DIFF_W     = 26;
    localparam int COUNT_W    = 10;
    localparam int POWER_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int P_TERM_W   = ERR_W + GAIN_W + 1;
    localparam int I_TERM_W   = INTEG_W + GAIN_W + 1;
    localparam int D_TERM_W   = DIFF_W + GAIN_W + 1;
    localparam int SUM_W      = D_TERM_W + 2;
    localparam int SETTLE_TOL = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

    localparam logic [GAIN_W-1:0]  KP_RST             = 24'd452;
    localparam logic [GAIN_W-1:0]  KI_RST             = 24'd2949;
    localparam logic [GAIN_W-1:0]  KD_RST             = 24'd3277;
    localparam logic [15:0]        MAX_POWER_RST      = 16'd26214;
    localparam logic [COUNT_W-1:0] SETTLE_SAMPLES_RST = 10'd30;
    localparam logic [15:0]        INTEGRAL_ZONE_RST  = 16'd768;
    localparam logic [15:0]        INTEGRAL_LIMIT_RST = 16'd77;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_ANGLE   = 3'd0,
        REG_KP             = 3'd1,
        REG_KI             = 3'd2,
        REG_KD             = 3'd3,
        REG_MAX_POWER      = 3'd4,
        REG_SETTLE_SAMPLES = 3'd5,
        REG_INTEGRAL_ZONE  = 3'd6,
        REG_INTEGRAL_LIMIT = 3'd7
    } pht_reg_e;

    typedef struct packed {
        logic signed [GYRO_W-1:0] target_angle;
        logic [GAIN_W-1:0]        kp;
        logic [GAIN_W-1:0]        ki;
        logic [GAIN_W-1:0]        kd;
        logic [15:0]              max_power;
        logic [COUNT_W-1:0]       settle_samples;
        logic [15:0]              integral_zone;
        logic [15:0]              integral_limit;
    } pht_cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DIFF_W-1:0]  diff;
        logic                      settled;
    } pht_err_t;

    typedef struct packed {
        logic signed [P_TERM_W-1:0] p_term;
        logic signed [I_TERM_W-1:0] i_term;
        logic signed [D_TERM_W-1:0] d_term;
        logic signed [ERR_W-1:0]    err;
        logic                       settled;
    } pht_prod_t;

    typedef struct packed {
        logic signed [POWER_W-1:0] drive_power;
        logic signed [ERR_W-1:0]   heading_error;
        logic                      settled;
    } pht_result_t;

endpackage

/* rtl/core/pht_error_stage.sv */
// ----------------------------------------------------------------------------
// pht_error_stage
// Heading error, integral zone, derivative and settle counter; owns the
// loop state and registers one item per cycle unless its output stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pht_error_stage #(
    parameter int ERROR_FRAC_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pht_pkg::pht_cfg_t                 cfg,
    input  logic                              i_valid,
    output logic                              i_ready,
    input  logic signed [pht_pkg::GYRO_W-1:0] gyro_a,
    input  logic signed [pht_pkg::GYRO_W-1:0] gyro_b,
    input  logic                              start_req,
    output logic                              o_valid,
    input  logic                              o_ready,
    output pht_pkg::pht_err_t                 o_data
);
    import pht_pkg::*;

    localparam int RAW_W  = GYRO_W + ERROR_FRAC_BITS + 2;
    localparam int CALC_W = (RAW_W > ERR_W) ? RAW_W : ERR_W + 1;
    localparam logic [ERR_W-1:0] TOL = ERR_W'(SETTLE_TOL) << ERROR_FRAC_BITS;

    logic                      vld_reg, vld_next;
    pht_err_t                  data_reg, data_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic [COUNT_W-1:0]        count_reg, count_next;

    logic                      adv;
    logic signed [CALC_W-1:0]  tgt_ext, gyro_diff, raw_err;
    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   prev_eff;
    logic signed [INTEG_W-1:0] integ_eff, integ_sum, integ_raw, integ, lim;
    logic [COUNT_W-1:0]        count_eff;
    logic [ERR_W-1:0]          abs_err;
    logic                      settled_now, in_zone, far_off;
    logic signed [DIFF_W-1:0]  diff;

    assign i_ready = !vld_reg || o_ready;
    assign adv     = i_valid && i_ready;
    assign o_valid = vld_reg;
    assign o_data  = data_reg;

    always_comb begin
        tgt_ext   = CALC_W'(cfg.target_angle);
        gyro_diff = CALC_W'(gyro_a) - CALC_W'(gyro_b);
        raw_err   = -(tgt_ext <<< ERROR_FRAC_BITS) - (gyro_diff <<< (ERROR_FRAC_BITS - 1));
        if (raw_err > CALC_W'(ERR_MAX)) begin
            err = ERR_MAX;
        end else if (raw_err < CALC_W'(ERR_MIN)) begin
            err = ERR_MIN;
        end else begin
            err = raw_err[ERR_W-1:0];
        end

        prev_eff  = start_req ? '0 : prev_err_reg;
        integ_eff = start_req ? '0 : integ_reg;
        count_eff = start_req ? '0 : count_reg;

        settled_now = count_eff >= cfg.settle_samples;
        abs_err     = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        in_zone     = (abs_err < ERR_W'(cfg.integral_zone)) && (err != '0);
        far_off     = abs_err > TOL;

        integ_sum = integ_eff + err[INTEG_W-1:0];
        integ_raw = in_zone ? integ_sum : '0;
        lim       = signed'(INTEG_W'(cfg.integral_limit));
        if (integ_raw > lim) begin
            integ = lim;
        end else if (integ_raw < -lim) begin
            integ = -lim;
        end else begin
            integ = integ_raw;
        end

        diff = (err == '0) ? '0 : DIFF_W'(err) - DIFF_W'(prev_eff);
    end

    always_comb begin
        vld_next      = i_ready ? i_valid : vld_reg;
        data_next     = data_reg;
        prev_err_next = prev_err_reg;
        integ_next    = integ_reg;
        count_next    = count_reg;
        if (adv) begin
            data_next.err     = err;
            data_next.integ   = integ;
            data_next.diff    = diff;
            data_next.settled = settled_now;
            prev_err_next     = prev_eff;
            integ_next        = integ_eff;
            count_next        = count_eff;
            if (!settled_now) begin
                prev_err_next = err;
                integ_next    = integ;
                if (far_off) begin
                    count_next = '0;
                end else if (count_eff != COUNT_MAX) begin
                    count_next = count_eff + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= 1'b0;
            prev_err_reg <= '0;
            integ_reg    <= '0;
            count_reg    <= '0;
        end else begin
            vld_reg      <= vld_next;
            prev_err_reg <= prev_err_next;
            integ_reg    <= integ_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    `ASSERT_CLKRST(a_settled_holds_count, aclk, aresetn, (adv && settled_now && !start_req) |=> $stable(count_reg), "settle count moved on a settled item")
    `ASSERT_CLKRST(a_far_clears_count, aclk, aresetn, (adv && !settled_now && far_off) |=> (count_reg == '0), "settle count not restarted on large error")
    `ASSERT_CLKRST(a_start_clears, aclk, aresetn, (adv && start_req && settled_now) |=> (integ_reg == '0 && prev_err_reg == '0), "start did not clear loop state")

endmodule

/* rtl/core/pht_mult_stage.sv */
// ----------------------------------------------------------------------------
// pht_mult_stage
// Registered gain products for the proportional, integral and derivative
// terms.
// ----------------------------------------------------------------------------
module pht_mult_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  pht_pkg::pht_cfg_t  cfg,
    input  logic               i_valid,
    output logic               i_ready,
    input  pht_pkg::pht_err_t  i_data,
    output logic               o_valid,
    input  logic               o_ready,
    output pht_pkg::pht_prod_t o_data
);
    import pht_pkg::*;

    logic      vld_reg, vld_next;
    pht_prod_t data_reg, data_next;
    logic      adv;

    assign i_ready = !vld_reg || o_ready;
    assign adv     = i_valid && i_ready;
    assign o_valid = vld_reg;
    assign o_data  = data_reg;

    always_comb begin
        vld_next  = i_ready ? i_valid : vld_reg;
        data_next = data_reg;
        if (adv) begin
            data_next.p_term  = signed'({1'b0, cfg.kp}) * i_data.err;
            data_next.i_term  = signed'({1'b0, cfg.ki}) * i_data.integ;
            data_next.d_term  = signed'({1'b0, cfg.kd}) * i_data.diff;
            data_next.err     = i_data.err;
            data_next.settled = i_data.settled;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

/* rtl/core/pht_output_stage.sv */
// ----------------------------------------------------------------------------
// pht_output_stage
// Term sum with round half up, then power clamp, negation and result
// register; the drive is zero for settled items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pht_output_stage #(
    parameter int ERROR_FRAC_BITS = 8,
    parameter int GAIN_FRAC_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pht_pkg::pht_cfg_t    cfg,
    input  logic                 i_valid,
    output logic                 i_ready,
    input  pht_pkg::pht_prod_t   i_data,
    output logic                 o_valid,
    input  logic                 o_ready,
    output pht_pkg::pht_result_t o_data
);
    import pht_pkg::*;

    localparam int SHIFT = ERROR_FRAC_BITS + GAIN_FRAC_BITS - 15;
    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (SHIFT - 1);

    typedef struct packed {
        logic signed [SUM_W-1:0] power;
        logic signed [ERR_W-1:0] err;
        logic                    settled;
    } pht_sum_t;

    logic                    sum_vld_reg, sum_vld_next;
    pht_sum_t                sum_reg, sum_next;
    logic                    out_vld_reg, out_vld_next;
    pht_result_t             out_reg, out_next;
    logic                    sum_ready, sum_adv, out_adv;
    logic signed [SUM_W-1:0] total, max_s, clamped, negated;

    assign i_ready   = !sum_vld_reg || sum_ready;
    assign sum_adv   = i_valid && i_ready;
    assign sum_ready = !out_vld_reg || o_ready;
    assign out_adv   = sum_vld_reg && sum_ready;
    assign o_valid   = out_vld_reg;
    assign o_data    = out_reg;

    always_comb begin
        total = SUM_W'(i_data.p_term) + SUM_W'(i_data.i_term) + SUM_W'(i_data.d_term) + ROUND;
        sum_vld_next = i_ready ? i_valid : sum_vld_reg;
        sum_next     = sum_reg;
        if (sum_adv) begin
            sum_next.power   = total >>> SHIFT;
            sum_next.err     = i_data.err;
            sum_next.settled = i_data.settled;
        end
    end

    always_comb begin
        max_s = signed'(SUM_W'(cfg.max_power));
        if (sum_reg.power > max_s) begin
            clamped = max_s;
        end else if (sum_reg.power < -max_s) begin
            clamped = -max_s;
        end else begin
            clamped = sum_reg.power;
        end
        negated = -clamped;

        out_vld_next = sum_ready ? sum_vld_reg : out_vld_reg;
        out_next     = out_reg;
        if (out_adv) begin
            out_next.drive_power   = sum_reg.settled ? '0 : negated[POWER_W-1:0];
            out_next.heading_error = sum_reg.err;
            out_next.settled       = sum_reg.settled;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            sum_vld_reg <= sum_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        out_reg <= out_next;
    end

    `ASSERT_CLKRST(a_drive_in_limit, aclk, aresetn, (out_vld_reg && !out_reg.settled) |-> (out_reg.drive_power <= signed'(POWER_W'(cfg.max_power)) && out_reg.drive_power >= -signed'(POWER_W'(cfg.max_power))), "drive outside power limit")

endmodule

/* rtl/core/pid_heading_turn_control.sv */
// ----------------------------------------------------------------------------
// pid_heading_turn_control
// Heading PID turn controller with integral zone and settle detection.
// ----------------------------------------------------------------------------
// Takes one item per clock unless back-pressure holds it, and returns one
// result per item, in order. Each accepted item passes the input register,
// error and state update, gain multiplies, term sum, clamp and result
// register. The loop state (previous error, integral, settle count) is
// updated in the error stage alone, so consecutive items need no gap. Each
// stage holds its item under back-pressure and any empty stage keeps
// accepting. Configuration writes take effect on the next edge and belong
// to idle periods.
// ----------------------------------------------------------------------------
module pid_heading_turn_control #(
    parameter int ERROR_FRAC_BITS = 8,
    parameter int GAIN_FRAC_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wen,
    input  logic [pht_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pht_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [31:0]                           s_axis_tdata,  // gyro_a, gyro_b
    input  logic                                  s_axis_tuser,  // start_req
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [47:0]                           m_axis_tdata,  // drive_power, heading_error
    output logic                                  m_axis_tuser   // settled
);
    import pht_pkg::*;

    typedef struct packed {
        logic signed [GYRO_W-1:0] gyro_a;
        logic signed [GYRO_W-1:0] gyro_b;
        logic                     start_req;
    } pht_in_t;

    pht_cfg_t    cfg_reg;
    logic        in_vld_reg, in_vld_next;
    pht_in_t     in_reg, in_next;
    logic        err_ready, err_valid, mult_ready, mult_valid;
    pht_err_t    err_data;
    pht_prod_t   prod_data;
    pht_result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_angle   <= '0;
            cfg_reg.kp             <= KP_RST;
            cfg_reg.ki             <= KI_RST;
            cfg_reg.kd             <= KD_RST;
            cfg_reg.max_power      <= MAX_POWER_RST;
            cfg_reg.settle_samples <= SETTLE_SAMPLES_RST;
            cfg_reg.integral_zone  <= INTEGRAL_ZONE_RST;
            cfg_reg.integral_limit <= INTEGRAL_LIMIT_RST;
        end else if (cfg_wen) begin
            unique case (pht_reg_e'(cfg_index))
                REG_TARGET_ANGLE:   cfg_reg.target_angle   <= signed'(cfg_wdata[15:0]);
                REG_KP:             cfg_reg.kp             <= cfg_wdata;
                REG_KI:             cfg_reg.ki             <= cfg_wdata;
                REG_KD:             cfg_reg.kd             <= cfg_wdata;
                REG_MAX_POWER:      cfg_reg.max_power      <= cfg_wdata[15:0];
                REG_SETTLE_SAMPLES: cfg_reg.settle_samples <= cfg_wdata[COUNT_W-1:0];
                REG_INTEGRAL_ZONE:  cfg_reg.integral_zone  <= cfg_wdata[15:0];
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !in_vld_reg || err_ready;

    always_comb begin
        in_vld_next = s_axis_tready ? s_axis_tvalid : in_vld_reg;
        in_next     = in_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            in_next.gyro_a    = signed'(s_axis_tdata[15:0]);
            in_next.gyro_b    = signed'(s_axis_tdata[31:16]);
            in_next.start_req = s_axis_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg <= in_next;
    end

    pht_error_stage #(
        .ERROR_FRAC_BITS (ERROR_FRAC_BITS)
    ) u_error (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .i_valid   (in_vld_reg),
        .i_ready   (err_ready),
        .gyro_a    (in_reg.gyro_a),
        .gyro_b    (in_reg.gyro_b),
        .start_req (in_reg.start_req),
        .o_valid   (err_valid),
        .o_ready   (mult_ready),
        .o_data    (err_data)
    );

    logic out_ready;

    pht_mult_stage u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .i_valid (err_valid),
        .i_ready (mult_ready),
        .i_data  (err_data),
        .o_valid (mult_valid),
        .o_ready (out_ready),
        .o_data  (prod_data)
    );

    pht_output_stage #(
        .ERROR_FRAC_BITS (ERROR_FRAC_BITS),
        .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
    ) u_output (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .i_valid (mult_valid),
        .i_ready (out_ready),
        .i_data  (prod_data),
        .o_valid (m_axis_tvalid),
        .o_ready (m_axis_tready),
        .o_data  (result)
    );

    assign m_axis_tdata = {6'b0, result.heading_error, result.drive_power};
    assign m_axis_tuser = result.settled;

endmodule
